FILE: rtl/core/idtp_pkg.sv
// Shared types and constants for the ISO 8601 duration text parser.
// Depends on nothing; used by idtp_ctrl, idtp_dp, the top level, the checker and the testbench.
package idtp_pkg;

  localparam int unsigned ACC_W  = 128;
  localparam int unsigned DIV_W  = 40;   // holds 10^12
  localparam int unsigned POST_W = 36;   // holds 60 * 10^9
  localparam int unsigned MANT_W = 60;

  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_Y     = 8'h59;
  localparam logic [7:0] CH_M     = 8'h4d;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_POINT = 8'h2e;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_P     = 2'd1,
    ST_BAD_NUM  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PH_FIRST  = 3'b001,
    PH_TOKENS = 3'b010,
    PH_STOP   = 3'b100
  } phase_t;

  typedef struct packed {
    logic take;
    logic exec_char;
    logic mul_step;
    logic div_step;
    logic round;
    logic mul2_load;
    logic add;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic unit_math;
    logic is_last;
    logic mul_done;
    logic div_done;
    logic q_ovf;
    logic out_free;
  } dp_stat_t;

  function automatic logic [63:0] pow10(input logic [4:0] n);
    logic [63:0] p;
    case (n)
      5'd0:  p = 64'd1;
      5'd1:  p = 64'd10;
      5'd2:  p = 64'd100;
      5'd3:  p = 64'd1000;
      5'd4:  p = 64'd10000;
      5'd5:  p = 64'd100000;
      5'd6:  p = 64'd1000000;
      5'd7:  p = 64'd10000000;
      5'd8:  p = 64'd100000000;
      5'd9:  p = 64'd1000000000;
      5'd10: p = 64'd10000000000;
      5'd11: p = 64'd100000000000;
      5'd12: p = 64'd1000000000000;
      5'd13: p = 64'd10000000000000;
      5'd14: p = 64'd100000000000000;
      5'd15: p = 64'd1000000000000000;
      5'd16: p = 64'd10000000000000000;
      5'd17: p = 64'd100000000000000000;
      5'd18: p = 64'd1000000000000000000;
      5'd19: p = 64'd10000000000000000000;
      default: p = 64'd0;
    endcase
    return p;
  endfunction

endpackage

FILE: rtl/core/idtp_ctrl.sv
// Sequencer for the duration parser: steps the datapath through each item.
// Depends on idtp_pkg.
module idtp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output idtp_pkg::dp_cmd_t cmd,
  input  idtp_pkg::dp_stat_t stat
);
  import idtp_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CHAR  = 9'b000000010,
    S_MUL1  = 9'b000000100,
    S_DIV   = 9'b000001000,
    S_ROUND = 9'b000010000,
    S_CHECK = 9'b000100000,
    S_MUL2  = 9'b001000000,
    S_ADD   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  state_t end_state;

  assign in_stall  = (state_r != S_IDLE);
  assign end_state = stat.is_last ? S_DONE : S_IDLE;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_CHAR;
        end
      end
      S_CHAR: begin
        cmd.exec_char = 1'b1;
        state_nxt = stat.unit_math ? S_MUL1 : end_state;
      end
      S_MUL1: begin
        if (stat.mul_done) state_nxt = S_DIV;
        else cmd.mul_step = 1'b1;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) state_nxt = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.mul2_load = 1'b1;
        state_nxt = stat.q_ovf ? end_state : S_MUL2;
      end
      S_MUL2: begin
        if (stat.mul_done) state_nxt = S_ADD;
        else cmd.mul_step = 1'b1;
      end
      S_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = end_state;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule

FILE: rtl/core/idtp_dp.sv
// Datapath for the duration parser: token state, shift-add multiplier,
// restoring divider by 10^n, total and result register. Depends on idtp_pkg.
module idtp_dp #(
  parameter int unsigned TICKS_PER_SECOND = 1000000000,
  parameter int unsigned FRAC_DIGITS      = 9,
  parameter int unsigned MANTISSA_DIGITS  = 18
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         in_char_code,
  input  logic               in_char_valid,
  input  logic               in_is_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] out_duration_ticks,
  output logic [1:0]         out_parse_status,
  input  idtp_pkg::dp_cmd_t  cmd,
  output idtp_pkg::dp_stat_t stat
);
  import idtp_pkg::*;

  localparam logic [63:0] TPS       = 64'(TICKS_PER_SECOND);
  localparam logic [63:0] MUL_YEAR  = 64'd31556952 * TPS;
  localparam logic [63:0] MUL_MONTH = 64'd2629746 * TPS;
  localparam logic [63:0] MUL_DAY   = 64'd86400 * TPS;
  localparam logic [63:0] POST_HOUR = 64'd60 * TPS;
  localparam logic [63:0] POST_MS   = TPS / 64'd1000;
  localparam logic [63:0] LIM       = pow10(5'(MANTISSA_DIGITS));
  localparam logic [63:0] LIM_DIV10 = pow10(5'(MANTISSA_DIGITS - 1));
  localparam logic [3:0]  FRAC_MAX  = 4'(FRAC_DIGITS);

  // item latch
  logic [7:0] ch_r, ch_nxt;
  logic       cv_r, cv_nxt, last_r, last_nxt;
  // parse state
  phase_t phase_r, phase_nxt;
  logic   tm_r, tm_nxt, neg_r, neg_nxt, started_r, started_nxt, dseen_r, dseen_nxt;
  logic [1:0] pc_r, pc_nxt;
  logic [MANT_W-1:0] mant_r, mant_nxt;
  logic [3:0]  fc_r, fc_nxt;
  logic [63:0] total_r, total_nxt;
  logic [1:0]  err_r, err_nxt;
  // arithmetic
  logic [ACC_W-1:0] acc_r, acc_nxt, mcand_r, mcand_nxt;
  logic [63:0]       mplr_r, mplr_nxt;
  logic [DIV_W-1:0]  dvs_r, dvs_nxt, rem_r, rem_nxt;
  logic [6:0]        cnt_r, cnt_nxt;
  logic [POST_W-1:0] post_r, post_nxt;
  logic              rnd_r, rnd_nxt;
  // result
  logic        ov_r, ov_nxt;
  logic [63:0] ot_r, ot_nxt;
  logic [1:0]  os_r, os_nxt;

  logic        numeric, is_digit, do_num, math_hit, math_rnd;
  logic [63:0] math_mul, math_post, m10d, vsum, fin_ticks, dvs_load;
  logic [DIV_W:0] trial;
  logic [64:0] sum65;
  logic [1:0]  fin_status;

  assign is_digit = (ch_r >= CH_ZERO) && (ch_r <= CH_NINE);
  assign numeric  = is_digit || (ch_r == CH_POINT);
  assign m10d     = {1'b0, mant_r, 3'b000} + {3'b000, mant_r, 1'b0}
                  + {60'd0, 4'(ch_r - CH_ZERO)};
  assign trial    = {rem_r, acc_r[ACC_W-1]};
  assign vsum     = neg_r ? (64'd0 - {1'b0, acc_r[62:0]}) : {1'b0, acc_r[62:0]};
  assign sum65    = {total_r[63], total_r} + {vsum[63], vsum};
  assign dvs_load = pow10({1'b0, fc_r});

  always_comb begin
    math_hit  = 1'b1;
    math_rnd  = 1'b0;
    math_mul  = MUL_DAY;
    math_post = 64'd1;
    case (ch_r)
      CH_Y: math_mul = MUL_YEAR;
      CH_D: math_mul = MUL_DAY;
      CH_M: begin
        if (tm_r) begin
          math_mul  = 64'd60;
          math_post = TPS;
          math_rnd  = 1'b1;
        end else begin
          math_mul = MUL_MONTH;
        end
      end
      CH_H: begin
        math_mul  = 64'd60;
        math_post = POST_HOUR;
        math_rnd  = 1'b1;
      end
      CH_S: begin
        math_mul  = 64'd1000;
        math_post = POST_MS;
        math_rnd  = 1'b1;
      end
      default: math_hit = 1'b0;
    endcase
  end

  assign fin_status = (err_r == ST_OK && phase_r == PH_FIRST) ? ST_NO_P : err_r;
  assign fin_ticks  = (fin_status == ST_OK) ? total_r : 64'd0;

  always_comb begin
    ch_nxt = ch_r; cv_nxt = cv_r; last_nxt = last_r;
    phase_nxt = phase_r; tm_nxt = tm_r; neg_nxt = neg_r;
    started_nxt = started_r; dseen_nxt = dseen_r; pc_nxt = pc_r;
    mant_nxt = mant_r; fc_nxt = fc_r; total_nxt = total_r; err_nxt = err_r;
    acc_nxt = acc_r; mcand_nxt = mcand_r; mplr_nxt = mplr_r; dvs_nxt = dvs_r;
    rem_nxt = rem_r; cnt_nxt = cnt_r; post_nxt = post_r; rnd_nxt = rnd_r;
    ov_nxt = ov_r && out_stall; ot_nxt = ot_r; os_nxt = os_r;
    do_num = 1'b0;

    if (cmd.take) begin
      ch_nxt   = in_char_code;
      cv_nxt   = in_char_valid;
      last_nxt = in_is_last;
    end

    if (cmd.exec_char && cv_r) begin
      unique case (phase_r)
        PH_FIRST: begin
          if (ch_r == CH_P) phase_nxt = PH_TOKENS;
          else begin
            err_nxt   = ST_NO_P;
            phase_nxt = PH_STOP;
          end
        end
        PH_TOKENS: begin
          if (!started_r) begin
            if (!tm_r && ch_r == CH_T) tm_nxt = 1'b1;
            else if (ch_r == CH_PLUS || ch_r == CH_MINUS) begin
              started_nxt = 1'b1;
              neg_nxt     = (ch_r == CH_MINUS);
            end else if (!numeric) phase_nxt = PH_STOP;
            else begin
              started_nxt = 1'b1;
              do_num      = 1'b1;
            end
          end else if (numeric) do_num = 1'b1;
          else if (!dseen_r) begin
            err_nxt   = ST_BAD_NUM;
            phase_nxt = PH_STOP;
          end else if (math_hit) begin
            acc_nxt   = '0;
            mcand_nxt = {{(ACC_W-MANT_W){1'b0}}, mant_r};
            mplr_nxt  = math_mul;
            post_nxt  = math_post[POST_W-1:0];
            rnd_nxt   = math_rnd;
            dvs_nxt   = dvs_load[DIV_W-1:0];
            rem_nxt   = '0;
            cnt_nxt   = '0;
          end else begin
            started_nxt = 1'b0; neg_nxt = 1'b0; dseen_nxt = 1'b0;
            pc_nxt = '0; mant_nxt = '0; fc_nxt = '0;
          end
        end
        default: ;
      endcase
    end

    if (do_num) begin
      if (ch_r == CH_POINT) begin
        if (pc_r != 2'd2) pc_nxt = pc_r + 2'd1;
      end else if (pc_r != 2'd2) begin
        dseen_nxt = 1'b1;
        if (pc_r == 2'd0) begin
          if ({4'd0, mant_r} >= LIM_DIV10 && m10d >= LIM) begin
            err_nxt   = ST_OVERFLOW;
            phase_nxt = PH_STOP;
          end else mant_nxt = m10d[MANT_W-1:0];
        end else if (fc_r < FRAC_MAX && m10d < LIM) begin
          mant_nxt = m10d[MANT_W-1:0];
          fc_nxt   = fc_r + 4'd1;
        end
      end
    end

    if (cmd.mul_step) begin
      if (mplr_r[0]) acc_nxt = acc_r + mcand_r;
      mcand_nxt = {mcand_r[ACC_W-2:0], 1'b0};
      mplr_nxt  = {1'b0, mplr_r[63:1]};
    end

    if (cmd.div_step) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = DIV_W'(trial - {1'b0, dvs_r});
        acc_nxt = {acc_r[ACC_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DIV_W-1:0];
        acc_nxt = {acc_r[ACC_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 7'd1;
    end

    // round half away from zero on the magnitude
    if (cmd.round && rnd_r && {rem_r, 1'b0} >= {1'b0, dvs_r}) acc_nxt = acc_r + 1'b1;

    if (cmd.mul2_load) begin
      if (acc_r[ACC_W-1:64] != '0) begin
        err_nxt   = ST_OVERFLOW;
        phase_nxt = PH_STOP;
      end else begin
        mcand_nxt = {64'd0, acc_r[63:0]};
        mplr_nxt  = {{(64-POST_W){1'b0}}, post_r};
        acc_nxt   = '0;
      end
    end

    if (cmd.add) begin
      if (acc_r[ACC_W-1:63] != '0 || sum65[64] != sum65[63]) begin
        err_nxt   = ST_OVERFLOW;
        phase_nxt = PH_STOP;
      end else begin
        total_nxt   = sum65[63:0];
        started_nxt = 1'b0; neg_nxt = 1'b0; dseen_nxt = 1'b0;
        pc_nxt = '0; mant_nxt = '0; fc_nxt = '0;
      end
    end

    if (cmd.finish) begin
      ov_nxt = 1'b1;
      ot_nxt = fin_ticks;
      os_nxt = fin_status;
      phase_nxt = PH_FIRST; tm_nxt = 1'b0; total_nxt = '0; err_nxt = ST_OK;
      started_nxt = 1'b0; neg_nxt = 1'b0; dseen_nxt = 1'b0;
      pc_nxt = '0; mant_nxt = '0; fc_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST; tm_r <= 1'b0; neg_r <= 1'b0; started_r <= 1'b0;
      dseen_r <= 1'b0; pc_r <= '0; mant_r <= '0; fc_r <= '0;
      total_r <= '0; err_r <= ST_OK; ov_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt; tm_r <= tm_nxt; neg_r <= neg_nxt; started_r <= started_nxt;
      dseen_r <= dseen_nxt; pc_r <= pc_nxt; mant_r <= mant_nxt; fc_r <= fc_nxt;
      total_r <= total_nxt; err_r <= err_nxt; ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r <= ch_nxt; cv_r <= cv_nxt; last_r <= last_nxt;
    acc_r <= acc_nxt; mcand_r <= mcand_nxt; mplr_r <= mplr_nxt;
    dvs_r <= dvs_nxt; rem_r <= rem_nxt; cnt_r <= cnt_nxt;
    post_r <= post_nxt; rnd_r <= rnd_nxt;
    ot_r <= ot_nxt; os_r <= os_nxt;
  end

  assign stat.unit_math = cv_r && phase_r == PH_TOKENS && started_r && !numeric
                          && dseen_r && math_hit;
  assign stat.is_last   = last_r;
  assign stat.mul_done  = (mplr_r == 64'd0);
  assign stat.div_done  = (cnt_r == 7'd127);
  assign stat.q_ovf     = (acc_r[ACC_W-1:64] != '0);
  assign stat.out_free  = !ov_r || !out_stall;

  assign out_valid          = ov_r;
  assign out_duration_ticks = ot_r;
  assign out_parse_status   = os_r;

endmodule

FILE: rtl/core/iso_duration_text_parser_top.sv
// Top level of the ISO 8601 duration text parser.
// Depends on idtp_pkg, idtp_ctrl and idtp_dp.
//
//  channel | ports                                          | accepted when
//  in      | in_char_code, in_char_valid, in_is_last        | in_valid && !in_stall
//  out     | out_duration_ticks, out_parse_status           | out_valid && !out_stall
//
// Steps: a sign, digit, point or ignored character is latched, then updates the
// parse state. A unit letter that scales (Y M D H S) also runs a shift-add
// multiply of mantissa by unit factor (one multiplier bit a cycle, until the
// multiplier is zero), a restoring divide by 10^fraction digits (one quotient
// bit a cycle), round, overflow check, a second shift-add multiply by the post
// factor, then the add to total.
// A last item then goes to a done state that loads the result register when free.
// Reset (rst_n low, synchronous) clears parse state and the result valid.
// The input is stalled from acceptance until the item is fully processed; a last
// item also waits there while a stalled result still holds the result register.
module iso_duration_text_parser_top #(
  parameter int unsigned TICKS_PER_SECOND = 1000000000,
  parameter int unsigned FRAC_DIGITS      = 9,
  parameter int unsigned MANTISSA_DIGITS  = 18
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_char_code,
  input  logic               in_char_valid,
  input  logic               in_is_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] out_duration_ticks,
  output logic [1:0]         out_parse_status
);
  import idtp_pkg::*;

  dp_cmd_t  cmd;   // sequencer -> datapath
  dp_stat_t stat;  // datapath -> sequencer

  idtp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  idtp_dp #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND),
    .FRAC_DIGITS      (FRAC_DIGITS),
    .MANTISSA_DIGITS  (MANTISSA_DIGITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_char_code       (in_char_code),
    .in_char_valid      (in_char_valid),
    .in_is_last         (in_is_last),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_duration_ticks (out_duration_ticks),
    .out_parse_status   (out_parse_status),
    .cmd                (cmd),
    .stat               (stat)
  );

endmodule

FILE: rtl/core/idtp_checker.sv
// Port-level checks for the duration parser, bound to the top level.
// Depends on idtp_pkg and iso_duration_text_parser_top.
module idtp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_duration_ticks,
  input logic [1:0]  out_parse_status
);
  import idtp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_duration_ticks)
                               && $stable(out_parse_status))
    else $error("stalled result changed");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_parse_status != ST_OK |-> out_duration_ticks == 64'd0)
    else $error("error result with nonzero ticks");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not held off while item is processed");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared with no item in progress");

endmodule

bind iso_duration_text_parser_top idtp_checker u_idtp_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_duration_ticks (out_duration_ticks),
  .out_parse_status   (out_parse_status)
);

FILE: dv/tb.sv
// Self-checking testbench for iso_duration_text_parser_top.
// Depends on idtp_pkg and the parser RTL; a scoreboard class predicts each result.

class duration_scoreboard;
  localparam longint unsigned TPS      = 64'd1000000000;
  localparam longint unsigned INT64MAX = 64'h7fffffffffffffff;
  localparam int unsigned     FRAC_MAX = 9;
  localparam int unsigned     MANT_DIG = 18;

  // parser state
  int unsigned        phase;   // 0 first char, 1 tokens, 2 stopped
  bit                 tmode;
  bit                 neg;
  bit                 started;
  bit                 dseen;
  int unsigned        pcount;
  logic [63:0]        mant;
  int unsigned        fdc;
  logic signed [63:0] total;
  logic [1:0]         err;

  logic signed [63:0] exp_ticks[$];
  logic [1:0]         exp_status[$];
  int                 mismatches;
  int                 checked;

  function new();
    mismatches = 0;
    checked = 0;
    reset_parse();
  endfunction

  function logic [127:0] pow10w(int unsigned n);
    logic [127:0] p;
    p = 128'd1;
    for (int i = 0; i < n; i++) p = p * 128'd10;
    return p;
  endfunction

  function void clear_token();
    started = 0;
    neg = 0;
    dseen = 0;
    pcount = 0;
    mant = 0;
    fdc = 0;
  endfunction

  function void reset_parse();
    phase = 0;
    tmode = 0;
    total = 0;
    err = idtp_pkg::ST_OK;
    clear_token();
  endfunction

  function void set_error(logic [1:0] code);
    err = code;
    phase = 2;
  endfunction

  // total += sign * round_or_trunc(mant * mul / 10^fdc) * post
  function void add_scaled(logic [63:0] mul, logic [63:0] post, bit rounded);
    logic [127:0]        prod;
    logic [127:0]        dv;
    logic [127:0]        q;
    logic [127:0]        r;
    logic [63:0]         mag;
    logic signed [64:0]  sum;
    prod = {64'd0, mant} * {64'd0, mul};
    dv = pow10w(fdc);
    q = prod / dv;
    r = prod % dv;
    if (rounded && r >= dv - r) q = q + 128'd1;
    if (post == 0) post = 64'd1;
    if (q > {64'd0, INT64MAX / post}) begin
      set_error(idtp_pkg::ST_OVERFLOW);
      return;
    end
    mag = q[63:0] * post;
    if (neg) sum = $signed({total[63], total}) - $signed({1'b0, mag});
    else sum = $signed({total[63], total}) + $signed({1'b0, mag});
    if (sum[64] != sum[63]) begin
      set_error(idtp_pkg::ST_OVERFLOW);
      return;
    end
    total = sum[63:0];
  endfunction

  function void number_char(logic [7:0] ch);
    logic [63:0] lim;
    logic [63:0] dg;
    lim = 64'(pow10w(MANT_DIG));
    if (ch == idtp_pkg::CH_POINT) begin
      if (pcount < 2) pcount++;
      return;
    end
    if (pcount >= 2) return;
    dg = {56'd0, 8'(ch - idtp_pkg::CH_ZERO)};
    dseen = 1;
    if (pcount == 0) begin
      if (mant * 64'd10 + dg >= lim) begin
        set_error(idtp_pkg::ST_OVERFLOW);
        return;
      end
      mant = mant * 64'd10 + dg;
    end else if (fdc < FRAC_MAX && mant * 64'd10 + dg < lim) begin
      mant = mant * 64'd10 + dg;
      fdc++;
    end
  endfunction

  function void unit_char(logic [7:0] ch);
    if (!dseen) begin
      set_error(idtp_pkg::ST_BAD_NUM);
      return;
    end
    if (ch == idtp_pkg::CH_Y) add_scaled(64'd31556952 * TPS, 64'd1, 0);
    else if (ch == idtp_pkg::CH_M && !tmode) add_scaled(64'd2629746 * TPS, 64'd1, 0);
    else if (ch == idtp_pkg::CH_D) add_scaled(64'd86400 * TPS, 64'd1, 0);
    else if (ch == idtp_pkg::CH_H) add_scaled(64'd60, 64'd60 * TPS, 1);
    else if (ch == idtp_pkg::CH_M) add_scaled(64'd60, TPS, 1);
    else if (ch == idtp_pkg::CH_S) add_scaled(64'd1000, TPS / 64'd1000, 1);
    if (phase == 1) clear_token();
  endfunction

  function void take_char(logic [7:0] ch);
    bit numeric;
    numeric = (ch >= idtp_pkg::CH_ZERO && ch <= idtp_pkg::CH_NINE) ||
              ch == idtp_pkg::CH_POINT;
    if (phase == 0) begin
      if (ch == idtp_pkg::CH_P) phase = 1;
      else set_error(idtp_pkg::ST_NO_P);
      return;
    end
    if (phase != 1) return;
    if (!started) begin
      if (!tmode && ch == idtp_pkg::CH_T) begin
        tmode = 1;
        return;
      end
      if (ch == idtp_pkg::CH_PLUS || ch == idtp_pkg::CH_MINUS) begin
        started = 1;
        neg = (ch == idtp_pkg::CH_MINUS);
        return;
      end
      if (!numeric) begin
        phase = 2;
        return;
      end
      started = 1;
      number_char(ch);
      return;
    end
    if (numeric) number_char(ch);
    else unit_char(ch);
  endfunction

  function void note_input(logic [7:0] ch, bit valid, bit last);
    logic [1:0] st;
    if (valid) take_char(ch);
    if (!last) return;
    st = err;
    if (st == idtp_pkg::ST_OK && phase == 0) st = idtp_pkg::ST_NO_P;
    exp_ticks.push_back(st == idtp_pkg::ST_OK ? total : 64'sd0);
    exp_status.push_back(st);
    reset_parse();
  endfunction

  function void check_result(logic signed [63:0] ticks, logic [1:0] status);
    logic signed [63:0] et;
    logic [1:0]         es;
    checked++;
    if (exp_ticks.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: unexpected result ticks=%0d status=%0d", ticks, status);
      return;
    end
    et = exp_ticks.pop_front();
    es = exp_status.pop_front();
    if (ticks !== et || status !== es) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: result %0d exp ticks=%0d status=%0d, got ticks=%0d status=%0d",
                 checked, et, es, ticks, status);
    end
  endfunction

  function int pending();
    return exp_ticks.size();
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import idtp_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int N_ITEMS     = 1700;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_stall;
  logic [7:0]         in_char_code = 0;
  logic               in_char_valid = 0;
  logic               in_is_last = 0;
  logic               out_valid;
  logic               out_stall = 0;
  logic signed [63:0] out_duration_ticks;
  logic [1:0]         out_parse_status;

  duration_scoreboard sb = new();

  int unsigned tx_idle_pct = 38;   // sender gap odds, percent
  int unsigned rx_idle_pct = 73;   // receiver stall odds, percent
  int          n_sent = 0;
  int          n_strings = 0;
  int          cycles = 0;

  iso_duration_text_parser_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_char_code(in_char_code), .in_char_valid(in_char_valid), .in_is_last(in_is_last),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_duration_ticks(out_duration_ticks), .out_parse_status(out_parse_status)
  );

  always #4 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side: check accepted items, then pick next stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_duration_ticks, out_parse_status);
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  // one item: optional idle gap, then hold until accepted
  task automatic send(input logic [7:0] ch, input bit cv, input bit last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid      <= 1;
    in_char_code  <= ch;
    in_char_valid <= cv;
    in_is_last    <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(ch, cv, last);
    n_sent++;
  endtask

  // a whole string; sometimes closed by a separate charless last item,
  // sometimes with charless filler items sprinkled in
  task automatic send_bytes(input logic [7:0] q[$], input bit trail_end);
    for (int i = 0; i < q.size(); i++) begin
      if ($urandom_range(19) == 0) send(8'($urandom_range(255)), 0, 0);
      send(q[i], 1, (i == q.size() - 1) && !trail_end);
    end
    if (trail_end || q.size() == 0) send(8'($urandom_range(255)), 0, 1);
    n_strings++;
  endtask

  task automatic send_str(input string s, input bit trail_end);
    logic [7:0] q[$];
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    send_bytes(q, trail_end);
  endtask

  function automatic void push_digits(ref logic [7:0] q[$], input int n);
    for (int i = 0; i < n; i++) q.push_back(CH_ZERO + 8'($urandom_range(9)));
  endfunction

  // well-formed duration with random content, occasionally bent
  function automatic void make_duration(ref logic [7:0] q[$]);
    logic [7:0] units[7];
    int         ntok;
    units = '{CH_Y, CH_M, CH_D, CH_H, CH_S, CH_T, 8'h51};
    q.delete();
    if ($urandom_range(19) != 0) q.push_back(CH_P);
    ntok = $urandom_range(4);
    for (int t = 0; t < ntok; t++) begin
      if ($urandom_range(5) == 0) q.push_back(CH_T);
      case ($urandom_range(5))
        0: q.push_back(CH_MINUS);
        1: q.push_back(CH_PLUS);
        default: ;
      endcase
      if ($urandom_range(9) == 0) push_digits(q, $urandom_range(21));
      else push_digits(q, $urandom_range(4));
      if ($urandom_range(2) == 0) begin
        q.push_back(CH_POINT);
        push_digits(q, $urandom_range(12));
        if ($urandom_range(15) == 0) q.push_back(CH_POINT);
      end
      if ($urandom_range(19) != 0)
        q.push_back(units[$urandom_range(6) < 5 ? $urandom_range(4) : $urandom_range(6)]);
    end
  endfunction

  initial begin
    logic [7:0] q[$];
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed strings
    send(8'($urandom_range(255)), 0, 1);      // empty string
    send_str("P", 0);
    send_str("X1D", 0);
    send_str("P1Y2M3DT4H5M6.5S", 0);
    send_str("PT-1.5M2.5S0.0005S", 1);
    send_str("P-.5D+7H", 0);
    send_str("P-D", 0);
    send_str("P.D", 0);
    send_str("P1.2.3D", 0);
    send_str("PT1Q2T3S", 0);
    send_str("P1DX5D", 0);
    send_str("P1D2", 0);
    send_str("P9999999999999999999D", 0);
    send_str("P999999999999Y", 0);
    send_str("P200Y200Y", 0);
    send_str("P-200Y-200Y", 0);
    send_str("PT0.1234567891234S0.99999H", 0);
    send_str("P999999999999999999.9S", 0);
    q = '{CH_P, 8'h00, 8'hff};
    send_bytes(q, 0);
    q = '{8'hff};
    send_bytes(q, 1);

    // random: first receiver stalls more, then sender idles more, then neither
    while (n_sent < N_ITEMS) begin
      if (n_sent < N_ITEMS / 3) begin
        tx_idle_pct = 38;
        rx_idle_pct = 73;
      end else if (n_sent < 2 * N_ITEMS / 3) begin
        tx_idle_pct = 73;
        rx_idle_pct = 38;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if ($urandom_range(9) < 8) begin
        make_duration(q);
      end else begin
        q.delete();
        repeat ($urandom_range(8)) q.push_back(8'($urandom_range(255)));
      end
      send_bytes(q, $urandom_range(3) == 0);
    end
    in_valid <= 0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (400) @(posedge clk);

    $display("sent %0d items in %0d strings, checked %0d results, %0d mismatches",
             n_sent, n_strings, sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule
